[design/assert_macros.svh]
// Assertion macros, included by tracker_pattern_unpacker_core.sv.
// Each use checks a property on the rising edge of clk, ignored while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define TPU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TPU_NEVER(lbl, cond, msg) \
  `TPU_ASSERT(lbl, !(cond), msg)

`endif

[design/tpu_pkg.sv]
package tpu_pkg;

  localparam int NUM_CHANNELS = 32;
  localparam int CH_AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] KIND_CELL    = 2'd0;
  localparam logic [1:0] KIND_ROW_END = 2'd1;
  localparam logic [1:0] KIND_PAT_END = 2'd2;
  localparam logic [1:0] KIND_BAD_CH  = 2'd3;

  localparam logic [1:0] CFG_XM_VOLUME_MODE  = 2'd0;
  localparam logic [1:0] CFG_EMPTY_NOTE_CODE = 2'd1;

  localparam logic [7:0] MASK_NOTE      = 8'h01;
  localparam logic [7:0] MASK_INST      = 8'h02;
  localparam logic [7:0] MASK_VOL       = 8'h04;
  localparam logic [7:0] MASK_FX        = 8'h08;
  localparam logic [7:0] MASK_REUSE_NOTE = 8'h10;
  localparam logic [7:0] MASK_REUSE_INST = 8'h20;
  localparam logic [7:0] MASK_REUSE_VOL  = 8'h40;
  localparam logic [7:0] MASK_REUSE_FX   = 8'h80;

  typedef struct packed {
    logic [7:0] mask;
    logic [7:0] note;
    logic [7:0] inst;
    logic [7:0] vol;
    logic [7:0] fx;
    logic [7:0] param;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[design/tpu_ram.sv]
module tpu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/tracker_pattern_unpacker_core.sv]
// Packed tracker pattern decoder.
// Input channel: one byte of packed pattern data per transaction on in_stream_byte;
// in_pattern_start marks the row-count byte that opens a pattern. Bytes seen while
// no pattern is open are dropped.
// Output channel: one event per transaction; out_kind tells a decoded cell, a row
// end, the pattern end or an invalid channel number (which also ends the row).
// Configuration: cfg_index selects the empty-volume mode (0) or the empty note
// code (1); cfg_ready is always high. Write only while the block is idle.
// Throughput: one byte per cycle while the output is not stalled. Each byte reads
// the per-channel store in the cycle it is accepted and is decoded in the next
// cycle, or later while the output stalls, when the store is written back; a write
// to the entry being read is forwarded. The byte that completes a result passes the
// input register and is decoded, and out_valid rises with the registered result.
// Reset: the decoder goes idle, the control registers take their defaults and
// every store entry reads as empty; no clearing pass is needed.
// Stall: while out_stall holds a waiting result, one more byte is taken and held,
// then in_stall rises until the result has been delivered.
module tracker_pattern_unpacker_core
  import tpu_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_stream_byte,
  input  logic             in_pattern_start,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_row,
  output logic [4:0]       out_channel,
  output logic [7:0]       out_note,
  output logic [7:0]       out_instrument,
  output logic [7:0]       out_volume,
  output logic [7:0]       out_effect,
  output logic [7:0]       out_effect_param,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [7:0]       cfg_data
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CHAN,
    PH_MASK,
    PH_NOTE,
    PH_INST,
    PH_VOL,
    PH_FX,
    PH_PARAM
  } phase_t;

  function automatic phase_t next_field(input phase_t from, input logic [7:0] m);
    phase_t ph;
    ph = PH_CHAN;
    if (from < PH_NOTE && (m & MASK_NOTE) != 8'h00) begin
      ph = PH_NOTE;
    end else if (from < PH_INST && (m & MASK_INST) != 8'h00) begin
      ph = PH_INST;
    end else if (from < PH_VOL && (m & MASK_VOL) != 8'h00) begin
      ph = PH_VOL;
    end else if (from < PH_FX && (m & MASK_FX) != 8'h00) begin
      ph = PH_FX;
    end
    return ph;
  endfunction

  logic xm_r, xm_nxt;
  logic [7:0] empty_note_r, empty_note_nxt;
  logic [7:0] clr_note_r, clr_note_nxt;
  logic [7:0] clr_vol_r, clr_vol_nxt;

  logic s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;
  logic s1_start_r, s1_start_nxt;
  logic rd_ok_r, rd_ok_nxt;
  logic fwd_hit_r, fwd_hit_nxt;
  entry_t fwd_data_r, fwd_data_nxt;

  phase_t phase_r, phase_nxt;
  logic [8:0] rows_total_r, rows_total_nxt;
  logic [7:0] row_r, row_nxt;
  logic [CH_AW-1:0] cur_ch_r, cur_ch_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] cell_note_r, cell_note_nxt;
  logic [7:0] cell_inst_r, cell_inst_nxt;
  logic [7:0] cell_vol_r, cell_vol_nxt;
  logic [7:0] cell_fx_r, cell_fx_nxt;
  entry_t entry_r, entry_nxt;
  logic [NUM_CHANNELS-1:0] valid_r, valid_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic [7:0] out_row_r, out_row_nxt;
  logic [4:0] out_channel_r, out_channel_nxt;
  logic [7:0] out_note_r, out_note_nxt;
  logic [7:0] out_inst_r, out_inst_nxt;
  logic [7:0] out_vol_r, out_vol_nxt;
  logic [7:0] out_fx_r, out_fx_nxt;
  logic [7:0] out_param_r, out_param_nxt;

  logic in_acc, b_fire, clr_now;
  logic ram_we;
  logic [CH_AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t e_rd, e_clr, bc_ent;
  logic [7:0] bc_mask, blank_vol;
  phase_t bc_phase;
  logic [6:0] ch_m1;
  logic [8:0] row_inc;
  logic last_row;
  logic res_vld;
  logic [1:0] res_kind;
  logic [4:0] res_channel;
  logic [7:0] res_note, res_inst, res_vol, res_fx, res_param;

  assign cfg_ready = 1'b1;
  assign b_fire = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_vld_r && out_valid_r && out_stall;
  assign in_acc = in_valid && !in_stall;
  assign clr_now = b_fire && s1_start_r;
  assign ram_raddr = CH_AW'(in_stream_byte[6:0] - 7'd1);

  tpu_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_CHANNELS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(cur_ch_r),
    .wdata(entry_nxt),
    .re   (in_acc),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    e_clr = '0;
    e_clr.note = clr_note_r;
    e_clr.vol = clr_vol_r;
    if (fwd_hit_r) begin
      e_rd = fwd_data_r;
    end else if (rd_ok_r) begin
      e_rd = entry_t'(ram_rdata);
    end else begin
      e_rd = e_clr;
    end
    blank_vol = xm_r ? 8'h00 : 8'hFF;
    ch_m1 = s1_byte_r[6:0] - 7'd1;
    row_inc = {1'b0, row_r} + 9'd1;
    last_row = row_inc >= rows_total_r;
    if (phase_r == PH_MASK) begin
      bc_mask = s1_byte_r;
      bc_ent = entry_r;
    end else begin
      bc_mask = e_rd.mask;
      bc_ent = e_rd;
    end
    bc_phase = next_field(PH_MASK, bc_mask);
  end

  always_comb begin
    xm_nxt = xm_r;
    empty_note_nxt = empty_note_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_XM_VOLUME_MODE: xm_nxt = cfg_data[0];
        CFG_EMPTY_NOTE_CODE: empty_note_nxt = cfg_data;
        default: ;
      endcase
    end

    s1_vld_nxt = in_acc ? 1'b1 : (b_fire ? 1'b0 : s1_vld_r);
    s1_byte_nxt = in_acc ? in_stream_byte : s1_byte_r;
    s1_start_nxt = in_acc ? in_pattern_start : s1_start_r;

    phase_nxt = phase_r;
    rows_total_nxt = rows_total_r;
    row_nxt = row_r;
    cur_ch_nxt = cur_ch_r;
    mask_nxt = mask_r;
    cell_note_nxt = cell_note_r;
    cell_inst_nxt = cell_inst_r;
    cell_vol_nxt = cell_vol_r;
    cell_fx_nxt = cell_fx_r;
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    clr_note_nxt = clr_note_r;
    clr_vol_nxt = clr_vol_r;
    ram_we = 1'b0;
    res_vld = 1'b0;
    res_kind = KIND_CELL;
    res_channel = 5'(cur_ch_r);
    res_note = cell_note_r;
    res_inst = cell_inst_r;
    res_vol = cell_vol_r;
    res_fx = cell_fx_r;
    res_param = '0;

    if (clr_now) begin
      rows_total_nxt = {1'b0, s1_byte_r} + 9'd1;
      row_nxt = '0;
      cur_ch_nxt = '0;
      mask_nxt = '0;
      cell_note_nxt = '0;
      cell_inst_nxt = '0;
      cell_vol_nxt = '0;
      cell_fx_nxt = '0;
      valid_nxt = '0;
      clr_note_nxt = empty_note_r;
      clr_vol_nxt = blank_vol;
      phase_nxt = PH_CHAN;
    end else if (b_fire) begin
      case (phase_r)
        PH_CHAN: begin
          if (s1_byte_r[6:0] == 7'd0 || ch_m1 >= 7'(NUM_CHANNELS)) begin
            res_vld = 1'b1;
            res_channel = '0;
            res_note = '0;
            res_inst = '0;
            res_vol = '0;
            res_fx = '0;
            if (s1_byte_r[6:0] != 7'd0) begin
              res_kind = KIND_BAD_CH;
            end else if (last_row) begin
              res_kind = KIND_PAT_END;
            end else begin
              res_kind = KIND_ROW_END;
            end
            if (last_row) begin
              phase_nxt = PH_IDLE;
            end else begin
              row_nxt = row_inc[7:0];
              phase_nxt = PH_CHAN;
            end
          end else begin
            cur_ch_nxt = CH_AW'(ch_m1);
            entry_nxt = e_rd;
            if (s1_byte_r[7]) begin
              phase_nxt = PH_MASK;
            end else begin
              mask_nxt = bc_mask;
              phase_nxt = bc_phase;
            end
          end
        end
        PH_MASK: begin
          mask_nxt = s1_byte_r;
          entry_nxt.mask = s1_byte_r;
          ram_we = 1'b1;
          phase_nxt = bc_phase;
        end
        PH_NOTE: begin
          cell_note_nxt = s1_byte_r;
          entry_nxt.note = s1_byte_r;
          ram_we = 1'b1;
          phase_nxt = next_field(PH_NOTE, mask_r);
        end
        PH_INST: begin
          cell_inst_nxt = s1_byte_r;
          entry_nxt.inst = s1_byte_r;
          ram_we = 1'b1;
          phase_nxt = next_field(PH_INST, mask_r);
        end
        PH_VOL: begin
          cell_vol_nxt = s1_byte_r;
          entry_nxt.vol = s1_byte_r;
          ram_we = 1'b1;
          phase_nxt = next_field(PH_VOL, mask_r);
        end
        PH_FX: begin
          cell_fx_nxt = s1_byte_r;
          entry_nxt.fx = s1_byte_r;
          ram_we = 1'b1;
          phase_nxt = PH_PARAM;
        end
        PH_PARAM: begin
          entry_nxt.param = s1_byte_r;
          ram_we = 1'b1;
          res_vld = 1'b1;
          res_param = s1_byte_r;
          phase_nxt = PH_CHAN;
        end
        default: ;
      endcase

      if ((phase_r == PH_CHAN && !s1_byte_r[7] && s1_byte_r[6:0] != 7'd0 &&
           ch_m1 < 7'(NUM_CHANNELS)) || phase_r == PH_MASK) begin
        cell_note_nxt = ((bc_mask & MASK_REUSE_NOTE) != 8'h00) ? bc_ent.note : empty_note_r;
        cell_inst_nxt = ((bc_mask & MASK_REUSE_INST) != 8'h00) ? bc_ent.inst : 8'h00;
        cell_vol_nxt = ((bc_mask & MASK_REUSE_VOL) != 8'h00) ? bc_ent.vol : blank_vol;
        cell_fx_nxt = ((bc_mask & MASK_REUSE_FX) != 8'h00) ? bc_ent.fx : 8'h00;
        if (bc_phase == PH_CHAN) begin
          res_vld = 1'b1;
          res_channel = 5'(cur_ch_nxt);
          res_param = ((bc_mask & MASK_REUSE_FX) != 8'h00) ? bc_ent.param : 8'h00;
        end
      end else if ((phase_r == PH_NOTE || phase_r == PH_INST || phase_r == PH_VOL) &&
                   phase_nxt == PH_CHAN) begin
        res_vld = 1'b1;
        res_param = ((mask_r & MASK_REUSE_FX) != 8'h00) ? entry_r.param : 8'h00;
      end
      res_note = cell_note_nxt;
      res_inst = cell_inst_nxt;
      res_vol = cell_vol_nxt;
      res_fx = cell_fx_nxt;
      if (res_kind != KIND_CELL) begin
        res_note = '0;
        res_inst = '0;
        res_vol = '0;
        res_fx = '0;
        res_param = '0;
      end
      if (ram_we) begin
        valid_nxt[cur_ch_r] = 1'b1;
      end
    end

    rd_ok_nxt = rd_ok_r;
    fwd_hit_nxt = fwd_hit_r;
    fwd_data_nxt = fwd_data_r;
    if (in_acc) begin
      rd_ok_nxt = !clr_now && valid_r[ram_raddr];
      fwd_hit_nxt = ram_we && (cur_ch_r == ram_raddr);
      fwd_data_nxt = entry_nxt;
    end

    out_valid_nxt = out_valid_r;
    out_kind_nxt = out_kind_r;
    out_row_nxt = out_row_r;
    out_channel_nxt = out_channel_r;
    out_note_nxt = out_note_r;
    out_inst_nxt = out_inst_r;
    out_vol_nxt = out_vol_r;
    out_fx_nxt = out_fx_r;
    out_param_nxt = out_param_r;
    if (b_fire && res_vld) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt = res_kind;
      out_row_nxt = row_r;
      out_channel_nxt = res_channel;
      out_note_nxt = res_note;
      out_inst_nxt = res_inst;
      out_vol_nxt = res_vol;
      out_fx_nxt = res_fx;
      out_param_nxt = res_param;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xm_r <= 1'b0;
      empty_note_r <= 8'hFF;
      clr_note_r <= 8'hFF;
      clr_vol_r <= 8'hFF;
      s1_vld_r <= 1'b0;
      rd_ok_r <= 1'b0;
      fwd_hit_r <= 1'b0;
      phase_r <= PH_IDLE;
      rows_total_r <= '0;
      row_r <= '0;
      cur_ch_r <= '0;
      mask_r <= '0;
      cell_note_r <= '0;
      cell_inst_r <= '0;
      cell_vol_r <= '0;
      cell_fx_r <= '0;
      valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      xm_r <= xm_nxt;
      empty_note_r <= empty_note_nxt;
      clr_note_r <= clr_note_nxt;
      clr_vol_r <= clr_vol_nxt;
      s1_vld_r <= s1_vld_nxt;
      rd_ok_r <= rd_ok_nxt;
      fwd_hit_r <= fwd_hit_nxt;
      phase_r <= phase_nxt;
      rows_total_r <= rows_total_nxt;
      row_r <= row_nxt;
      cur_ch_r <= cur_ch_nxt;
      mask_r <= mask_nxt;
      cell_note_r <= cell_note_nxt;
      cell_inst_r <= cell_inst_nxt;
      cell_vol_r <= cell_vol_nxt;
      cell_fx_r <= cell_fx_nxt;
      valid_r <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    s1_byte_r <= s1_byte_nxt;
    s1_start_r <= s1_start_nxt;
    fwd_data_r <= fwd_data_nxt;
    entry_r <= entry_nxt;
    out_kind_r <= out_kind_nxt;
    out_row_r <= out_row_nxt;
    out_channel_r <= out_channel_nxt;
    out_note_r <= out_note_nxt;
    out_inst_r <= out_inst_nxt;
    out_vol_r <= out_vol_nxt;
    out_fx_r <= out_fx_nxt;
    out_param_r <= out_param_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_row = out_row_r;
  assign out_channel = out_channel_r;
  assign out_note = out_note_r;
  assign out_instrument = out_inst_r;
  assign out_volume = out_vol_r;
  assign out_effect = out_fx_r;
  assign out_effect_param = out_param_r;

`include "assert_macros.svh"

  `TPU_ASSERT(a_start_clears, clr_now |=> phase_r == PH_CHAN && valid_r == '0 && row_r == '0, "pattern start did not reset the decoder")
  `TPU_NEVER(a_write_phase, ram_we && (phase_r == PH_IDLE || phase_r == PH_CHAN), "store written outside a field byte")
  `TPU_ASSERT(a_idle_holds, b_fire && !s1_start_r && phase_r == PH_IDLE |=> phase_r == PH_IDLE, "idle decoder left idle without a pattern start")
  `TPU_NEVER(a_no_overrun, in_acc && s1_vld_r && !b_fire, "held byte overwritten before it was decoded")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import tpu_pkg::*;

  localparam int WD_LIMIT = 2000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHAN, ST_MASK, ST_NOTE, ST_INST, ST_VOL, ST_FX, ST_PARAM
  } dec_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] row;
    logic [4:0] channel;
    logic [7:0] note;
    logic [7:0] inst;
    logic [7:0] vol;
    logic [7:0] fx;
    logic [7:0] param;
  } event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    event_t     ev;
  } stim_t;

  localparam event_t NO_EV = '0;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_stream_byte;
  logic       in_pattern_start;
  logic       out_valid;
  logic       out_stall;
  logic [1:0] out_kind;
  logic [7:0] out_row;
  logic [4:0] out_channel;
  logic [7:0] out_note;
  logic [7:0] out_instrument;
  logic [7:0] out_volume;
  logic [7:0] out_effect;
  logic [7:0] out_effect_param;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  tracker_pattern_unpacker_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .in_pattern_start (in_pattern_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_row          (out_row),
    .out_channel      (out_channel),
    .out_note         (out_note),
    .out_instrument   (out_instrument),
    .out_volume       (out_volume),
    .out_effect       (out_effect),
    .out_effect_param (out_effect_param),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of the decoder: registers, walk state and per-channel stores.
  logic       reg_xm;
  logic [7:0] reg_empty_note;
  dec_state_t dec_state;
  logic [8:0] rows_total;
  logic [7:0] row_idx;
  logic [6:0] cur_ch;
  logic [7:0] cur_mask;
  logic [7:0] cell_note, cell_inst, cell_vol, cell_fx;
  logic [7:0] sv_mask  [NUM_CHANNELS];
  logic [7:0] sv_note  [NUM_CHANNELS];
  logic [7:0] sv_inst  [NUM_CHANNELS];
  logic [7:0] sv_vol   [NUM_CHANNELS];
  logic [7:0] sv_fx    [NUM_CHANNELS];
  logic [7:0] sv_param [NUM_CHANNELS];

  stim_t      byte_q [$];
  event_t     pending_events [$];
  stim_t      dir_tab [26];
  logic [7:0] gen_mask [NUM_CHANNELS];
  int         gen_total;
  int         errors;
  int         in_count;
  int         in_gap;
  int         out_gap;
  int         calm_left;
  logic       calm;
  logic       hold_off;

  function automatic event_t mk_event(logic [1:0] kind, logic [7:0] row, logic [4:0] ch,
                                      logic [7:0] n, logic [7:0] i, logic [7:0] v,
                                      logic [7:0] f, logic [7:0] p);
    event_t e;
    e = '{kind, row, ch, n, i, v, f, p};
    return e;
  endfunction

  function automatic logic [7:0] blank_vol();
    return reg_xm ? 8'h00 : 8'hFF;
  endfunction

  task automatic clear_stores();
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      sv_mask[i]  = 8'h00;
      sv_note[i]  = reg_empty_note;
      sv_inst[i]  = 8'h00;
      sv_vol[i]   = blank_vol();
      sv_fx[i]    = 8'h00;
      sv_param[i] = 8'h00;
    end
  endtask

  task automatic reset_model();
    reg_xm = 1'b0;
    reg_empty_note = 8'hFF;
    dec_state = ST_IDLE;
    rows_total = '0;
    row_idx = '0;
    cur_ch = '0;
    cur_mask = '0;
    cell_note = '0;
    cell_inst = '0;
    cell_vol = '0;
    cell_fx = '0;
    clear_stores();
  endtask

  function automatic bit last_row();
    return ({1'b0, row_idx} + 9'd1) >= rows_total;
  endfunction

  task automatic advance_row();
    if (last_row()) begin
      dec_state = ST_IDLE;
    end else begin
      row_idx = row_idx + 8'd1;
      dec_state = ST_CHAN;
    end
  endtask

  function automatic dec_state_t next_field(dec_state_t from);
    if (from < ST_NOTE && (cur_mask & MASK_NOTE) != 8'h00) return ST_NOTE;
    if (from < ST_INST && (cur_mask & MASK_INST) != 8'h00) return ST_INST;
    if (from < ST_VOL && (cur_mask & MASK_VOL) != 8'h00) return ST_VOL;
    if (from < ST_FX && (cur_mask & MASK_FX) != 8'h00) return ST_FX;
    return ST_CHAN;
  endfunction

  task automatic finish_field(output bit got, output event_t r);
    logic [7:0] p;
    got = 1'b0;
    r = NO_EV;
    dec_state = next_field(dec_state);
    if (dec_state == ST_CHAN) begin
      p = ((cur_mask & MASK_REUSE_FX) != 8'h00) ? sv_param[cur_ch] : 8'h00;
      got = 1'b1;
      r = mk_event(KIND_CELL, row_idx, cur_ch[4:0], cell_note, cell_inst, cell_vol,
                   cell_fx, p);
    end
  endtask

  task automatic begin_cell(output bit got, output event_t r);
    cell_note = ((cur_mask & MASK_REUSE_NOTE) != 8'h00) ? sv_note[cur_ch] : reg_empty_note;
    cell_inst = ((cur_mask & MASK_REUSE_INST) != 8'h00) ? sv_inst[cur_ch] : 8'h00;
    cell_vol  = ((cur_mask & MASK_REUSE_VOL) != 8'h00) ? sv_vol[cur_ch] : blank_vol();
    cell_fx   = ((cur_mask & MASK_REUSE_FX) != 8'h00) ? sv_fx[cur_ch] : 8'h00;
    dec_state = ST_MASK;
    finish_field(got, r);
  endtask

  task automatic unpack_byte(input logic [7:0] b, input logic st, output bit got,
                             output event_t r);
    logic [6:0] ch7;
    got = 1'b0;
    r = NO_EV;
    ch7 = b[6:0];
    if (st) begin
      rows_total = {1'b0, b} + 9'd1;
      row_idx = '0;
      cur_ch = '0;
      cur_mask = '0;
      cell_note = '0;
      cell_inst = '0;
      cell_vol = '0;
      cell_fx = '0;
      clear_stores();
      dec_state = ST_CHAN;
    end else begin
      case (dec_state)
        ST_CHAN: begin
          if (ch7 == 7'd0) begin
            got = 1'b1;
            r = mk_event(last_row() ? KIND_PAT_END : KIND_ROW_END, row_idx, 5'd0,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            advance_row();
          end else if (int'(ch7) - 1 >= NUM_CHANNELS) begin
            got = 1'b1;
            r = mk_event(KIND_BAD_CH, row_idx, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            advance_row();
          end else begin
            cur_ch = ch7 - 7'd1;
            if (b[7]) begin
              dec_state = ST_MASK;
            end else begin
              cur_mask = sv_mask[cur_ch];
              begin_cell(got, r);
            end
          end
        end
        ST_MASK: begin
          cur_mask = b;
          sv_mask[cur_ch] = b;
          begin_cell(got, r);
        end
        ST_NOTE: begin
          cell_note = b;
          sv_note[cur_ch] = b;
          finish_field(got, r);
        end
        ST_INST: begin
          cell_inst = b;
          sv_inst[cur_ch] = b;
          finish_field(got, r);
        end
        ST_VOL: begin
          cell_vol = b;
          sv_vol[cur_ch] = b;
          finish_field(got, r);
        end
        ST_FX: begin
          cell_fx = b;
          sv_fx[cur_ch] = b;
          dec_state = ST_PARAM;
        end
        ST_PARAM: begin
          sv_param[cur_ch] = b;
          got = 1'b1;
          r = mk_event(KIND_CELL, row_idx, cur_ch[4:0], cell_note, cell_inst, cell_vol,
                       cell_fx, b);
          dec_state = ST_CHAN;
        end
        default: begin
        end
      endcase
    end
  endtask

  function automatic int idle_len(logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] rnd_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic st);
    byte_q.push_back('{b, st, 1'b0, NO_EV});
    gen_total++;
  endtask

  task automatic gen_entry(output bit row_done, output bit cut);
    int r;
    int nf;
    logic [6:0] ch;
    logic [7:0] cb;
    logic [7:0] m;
    row_done = 1'b0;
    cut = 1'b0;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      ch = 7'($urandom_range(NUM_CHANNELS, 126));
      cb = {1'b0, ch} + 8'd1;
      cb[7] = 1'($urandom_range(0, 1));
      push_byte(cb, 1'b0);
      row_done = 1'b1;
    end else begin
      ch = (r < 70) ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, NUM_CHANNELS - 1));
      cb = {1'b0, ch} + 8'd1;
      if ($urandom_range(0, 99) < 65) begin
        m = 8'($urandom_range(0, 255));
        gen_mask[ch] = m;
        push_byte({1'b1, cb[6:0]}, 1'b0);
        if ($urandom_range(0, 99) < 3) begin
          cut = 1'b1;
        end else begin
          push_byte(m, 1'b0);
        end
      end else begin
        m = gen_mask[ch];
        push_byte(cb, 1'b0);
      end
      if (!cut) begin
        nf = int'(m[0]) + int'(m[1]) + int'(m[2]) + 2 * int'(m[3]);
        repeat (nf) push_byte(rnd_byte(), 1'b0);
      end
    end
  endtask

  task automatic gen_row(output bit cut);
    int n;
    bit done;
    cut = 1'b0;
    done = 1'b0;
    n = $urandom_range(0, 4);
    for (int i = 0; i < n && !done && !cut; i++) gen_entry(done, cut);
    if (!done && !cut) begin
      if ($urandom_range(0, 99) < 4) begin
        push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
      push_byte($urandom_range(0, 1) ? 8'h80 : 8'h00, 1'b0);
    end
  endtask

  task automatic gen_pattern();
    int nrows;
    bit cut;
    logic [7:0] cnt;
    cut = 1'b0;
    cnt = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(0, 255)) :
                                         8'($urandom_range(0, 5));
    push_byte(cnt, 1'b1);
    foreach (gen_mask[i]) gen_mask[i] = 8'h00;
    nrows = int'(cnt) + 1;
    if (nrows > 8) nrows = $urandom_range(2, 8);
    for (int i = 0; i < nrows && !cut; i++) gen_row(cut);
    if ($urandom_range(0, 99) < 20) push_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic gen_phase(input int target);
    int first;
    bit cut;
    first = gen_total;
    if ($urandom_range(0, 99) < 40) repeat ($urandom_range(1, 3)) gen_row(cut);
    while (gen_total - first < target) gen_pattern();
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_valid || pending_events.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_XM_VOLUME_MODE) reg_xm = val[0];
    else if (idx == CFG_EMPTY_NOTE_CODE) reg_empty_note = val;
  endtask

  always @(posedge clk) begin
    if (calm_left == 0) begin
      calm <= ($urandom_range(0, 99) < 30);
      calm_left = $urandom_range(20, 120);
    end else begin
      calm_left--;
    end
  end

  always @(posedge clk) begin : drive_bytes
    bit got;
    event_t ev_out;
    stim_t cur;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        cur = byte_q.pop_front();
        unpack_byte(cur.data, cur.start, got, ev_out);
        if (cur.typed) pending_events.push_back(cur.ev);
        else if (got) pending_events.push_back(ev_out);
        in_count++;
        in_gap = idle_len(calm);
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (byte_q.size() > 0) begin
          in_valid <= 1'b1;
          in_stream_byte <= byte_q[0].data;
          in_pattern_start <= byte_q[0].start;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_events
    event_t seen;
    event_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{out_kind, out_row, out_channel, out_note, out_instrument, out_volume,
               out_effect, out_effect_param};
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: event with none pending: expected none, actual kind %0d row %0d",
                 $time, out_kind, out_row);
      end else begin
        want = pending_events.pop_front();
        if (seen !== want) begin
          errors++;
          $display("%0t: event mismatch: expected kind %0d row %0d ch %0d %h %h %h %h %h",
                   $time, want.kind, want.row, want.channel, want.note, want.inst,
                   want.vol, want.fx, want.param);
          $display("%0t:                 actual   kind %0d row %0d ch %0d %h %h %h %h %h",
                   $time, seen.kind, seen.row, seen.channel, seen.note, seen.inst,
                   seen.vol, seen.fx, seen.param);
        end
      end
    end
    if (out_gap > 0) out_gap--;
    else out_gap = idle_len(calm);
    out_stall <= hold_off || (out_gap > 0);
  end

  // The receiver holds off long enough for the decoder to fill up and stall its input.
  initial begin : pressure
    wait (in_count >= 250 && byte_q.size() > 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WD_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) quiet = 0;
      else quiet++;
    end
    $display("testbench NOT OK");
    $finish;
  end

  initial begin : main
    logic       xm;
    logic [7:0] en;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stream_byte = 8'h00;
    in_pattern_start = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = 8'h00;
    hold_off = 1'b0;
    calm = 1'b0;
    calm_left = 0;
    in_gap = 0;
    out_gap = 0;
    in_count = 0;
    errors = 0;
    gen_total = 0;
    foreach (gen_mask[i]) gen_mask[i] = 8'h00;
    reset_model();

    dir_tab[0]  = '{8'h55, 1'b0, 1'b0, NO_EV};
    dir_tab[1]  = '{8'h01, 1'b1, 1'b0, NO_EV};
    dir_tab[2]  = '{8'h81, 1'b0, 1'b0, NO_EV};
    dir_tab[3]  = '{8'hFF, 1'b0, 1'b0, NO_EV};
    dir_tab[4]  = '{8'h00, 1'b0, 1'b0, NO_EV};
    dir_tab[5]  = '{8'hFF, 1'b0, 1'b0, NO_EV};
    dir_tab[6]  = '{8'h00, 1'b0, 1'b0, NO_EV};
    dir_tab[7]  = '{8'hFF, 1'b0, 1'b0, NO_EV};
    dir_tab[8]  = '{8'h00, 1'b0, 1'b1,
                    mk_event(KIND_CELL, 8'd0, 5'd0, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00)};
    dir_tab[9]  = '{8'hA0, 1'b0, 1'b0, NO_EV};
    dir_tab[10] = '{8'hF0, 1'b0, 1'b1,
                    mk_event(KIND_CELL, 8'd0, 5'd31, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00)};
    dir_tab[11] = '{8'h7F, 1'b0, 1'b1,
                    mk_event(KIND_BAD_CH, 8'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)};
    dir_tab[12] = '{8'h01, 1'b0, 1'b0, NO_EV};
    dir_tab[13] = '{8'h12, 1'b0, 1'b0, NO_EV};
    dir_tab[14] = '{8'h34, 1'b0, 1'b0, NO_EV};
    dir_tab[15] = '{8'h56, 1'b0, 1'b0, NO_EV};
    dir_tab[16] = '{8'h78, 1'b0, 1'b0, NO_EV};
    dir_tab[17] = '{8'h9A, 1'b0, 1'b0, NO_EV};
    dir_tab[18] = '{8'h00, 1'b0, 1'b1,
                    mk_event(KIND_PAT_END, 8'd1, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)};
    dir_tab[19] = '{8'h00, 1'b0, 1'b0, NO_EV};
    dir_tab[20] = '{8'h00, 1'b1, 1'b0, NO_EV};
    dir_tab[21] = '{8'h82, 1'b0, 1'b0, NO_EV};
    dir_tab[22] = '{8'hFF, 1'b1, 1'b0, NO_EV};
    dir_tab[23] = '{8'h02, 1'b0, 1'b1,
                    mk_event(KIND_CELL, 8'd0, 5'd1, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00)};
    dir_tab[24] = '{8'h80, 1'b0, 1'b1,
                    mk_event(KIND_ROW_END, 8'd0, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)};
    dir_tab[25] = '{8'h21, 1'b0, 1'b1,
                    mk_event(KIND_BAD_CH, 8'd1, 5'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00)};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_tab[i]) byte_q.push_back(dir_tab[i]);
    wait_idle();

    for (int p = 1; p <= 7; p++) begin
      case (p)
        1: begin xm = 1'b1; en = 8'h00; end
        2: begin xm = 1'b1; en = 8'hFF; end
        3: begin xm = 1'b0; en = 8'h00; end
        4: begin xm = 1'b0; en = 8'hFF; end
        default: begin
          xm = 1'($urandom_range(0, 1));
          en = 8'($urandom_range(0, 255));
        end
      endcase
      write_reg(CFG_XM_VOLUME_MODE, {7'd0, xm});
      write_reg(CFG_EMPTY_NOTE_CODE, en);
      gen_phase(100);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
